@@ src/sodt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted object table package
// Shared types, operation and status codes, data type size map.
// ----------------------------------------------------------------------------
`default_nettype none
package sodt_pkg;

   localparam int unsigned TableDepthDefault = 256;
   localparam int unsigned KeyWidth = 32;
   localparam int unsigned ValueWidth = 64;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_SIZE   = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_READCL = 3'd3;
   localparam logic [2:0] OP_WRMARK = 3'd4;
   localparam logic [2:0] OP_WRITE  = 3'd5;
   localparam logic [2:0] OP_NEXTUP = 3'd6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BADNODE = 3'd1;
   localparam logic [2:0] ST_BADTYPE = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_DUP     = 3'd4;
   localparam logic [2:0] ST_MISSING = 3'd5;
   localparam logic [2:0] ST_NONEUPD = 3'd6;
   localparam logic [2:0] ST_DEFTYPE = 3'd7;

   localparam logic [1:0] CSR_NODE_MIN = 2'd0;
   localparam logic [1:0] CSR_NODE_MAX = 2'd1;
   localparam logic [1:0] CSR_DEF_LOW  = 2'd2;
   localparam logic [1:0] CSR_DEF_HIGH = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SRCH_CMP,
      S_PROBE,
      S_PROBE_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_RESULT
   } state_type;

   function automatic logic [3:0] type_bytes(input logic [15:0] t);
      logic [3:0] r;
      case (t)
         16'h0002, 16'h0005: r = 4'd1;
         16'h0003, 16'h0006: r = 4'd2;
         16'h0004, 16'h0007, 16'h0008: r = 4'd4;
         16'h0011, 16'h0015, 16'h001B: r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] size_mask(input logic [3:0] sz);
      logic [63:0] m;
      case (sz)
         4'd0: m = 64'h0;
         4'd1: m = 64'hFF;
         4'd2: m = 64'hFFFF;
         4'd3: m = 64'hFF_FFFF;
         4'd4: m = 64'hFFFF_FFFF;
         4'd5: m = 64'hFF_FFFF_FFFF;
         4'd6: m = 64'hFFFF_FFFF_FFFF;
         4'd7: m = 64'hFF_FFFF_FFFF_FFFF;
         default: m = '1;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

@@ src/sorted_object_dictionary_table.sv @@
// ----------------------------------------------------------------------------
// Sorted object dictionary table
// Key-sorted entry table with binary-search lookup, shifting insert and a
// sequential scan for the first updated entry.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | operation, key, data_type, value
// rsp     | out       | rsp_valid/rsp_ready  | status, size, value, found key
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One item at a time. Lookups make one memory read per search step; insert
// then shifts entries one at a time (a read and a write each); next updated
// reads entries in order. One table memory, one read and one write port.
// Reset clears the entry count and the configuration registers; the table is not cleared.
// req_ready is low from acceptance until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_object_dictionary_table #(
   parameter int unsigned TABLE_DEPTH = sodt_pkg::TableDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [7:0]  req_node_number,
   input  wire logic [15:0] req_object_index,
   input  wire logic [7:0]  req_object_subindex,
   input  wire logic [15:0] req_data_type,
   input  wire logic [63:0] req_write_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_object_size,
   output logic [63:0]      rsp_read_value,
   output logic             rsp_was_updated,
   output logic [7:0]       rsp_found_node,
   output logic [15:0]      rsp_found_index,
   output logic [7:0]       rsp_found_subindex,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned EW = 32 + 4 + 64 + 1;
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   wire [31:0] rd_key  = rd_ff[EW-1 -: 32];
   wire [3:0]  rd_size = rd_ff[68:65];
   wire [63:0] rd_val  = rd_ff[64:1];
   wire        rd_mark = rd_ff[0];

   sodt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [7:0]  nmin_ff, nmax_ff;
   logic [15:0] dlo_ff, dhi_ff;
   logic [2:0]  op_ff, op_in;
   logic [31:0] key_ff, key_in;
   logic [3:0]  isz_ff, isz_in;
   logic [63:0] wval_ff, wval_in;
   logic [EW-1:0] hold_ff, hold_in;
   logic [2:0]  st_ff, st_in;
   logic [3:0]  osz_ff, osz_in;
   logic [63:0] rv_ff, rv_in;
   logic        upd_ff, upd_in;
   logic [31:0] fkey_ff, fkey_in;

   wire [CW-1:0] mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   wire [3:0]    tsz = sodt_pkg::type_bytes(req_data_type);
   wire          deftype = (req_object_index >= dlo_ff) && (req_object_index <= dhi_ff);

   assign req_ready = (state_ff == sodt_pkg::S_IDLE);
   assign rsp_valid = (state_ff == sodt_pkg::S_RESULT);
   assign csr_ready = 1'b1;
   assign rsp_status = st_ff;
   assign rsp_object_size = osz_ff;
   assign rsp_read_value = rv_ff;
   assign rsp_was_updated = upd_ff;
   assign rsp_found_node = fkey_ff[31:24];
   assign rsp_found_index = fkey_ff[23:8];
   assign rsp_found_subindex = fkey_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sodt_pkg::S_IDLE;
         count_ff <= '0;
         nmin_ff <= 8'd1;
         nmax_ff <= 8'd127;
         dlo_ff <= 16'd1;
         dhi_ff <= 16'd607;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid) begin
            unique case (csr_index)
               sodt_pkg::CSR_NODE_MIN: nmin_ff <= csr_wdata[7:0];
               sodt_pkg::CSR_NODE_MAX: nmax_ff <= csr_wdata[7:0];
               sodt_pkg::CSR_DEF_LOW:  dlo_ff <= csr_wdata;
               sodt_pkg::CSR_DEF_HIGH: dhi_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      op_ff <= op_in;
      key_ff <= key_in;
      isz_ff <= isz_in;
      wval_ff <= wval_in;
      hold_ff <= hold_in;
      st_ff <= st_in;
      osz_ff <= osz_in;
      rv_ff <= rv_in;
      upd_ff <= upd_in;
      fkey_ff <= fkey_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      op_in = op_ff;
      key_in = key_ff;
      isz_in = isz_ff;
      wval_in = wval_ff;
      hold_in = hold_ff;
      st_in = st_ff;
      osz_in = osz_ff;
      rv_in = rv_ff;
      upd_in = upd_ff;
      fkey_in = fkey_ff;
      rd_addr = mid[AW-1:0];
      wr_en = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = hold_ff;
      unique case (state_ff)
         sodt_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               key_in = {req_node_number, req_object_index, req_object_subindex};
               isz_in = tsz;
               wval_in = req_write_value;
               st_in = sodt_pkg::ST_OK;
               osz_in = '0;
               rv_in = '0;
               upd_in = 1'b0;
               fkey_in = '0;
               lo_in = '0;
               hi_in = count_ff;
               ptr_in = '0;
               state_in = sodt_pkg::S_SEARCH;
               case (req_operation)
                  sodt_pkg::OP_INSERT: begin
                     if (req_node_number < nmin_ff || req_node_number > nmax_ff) begin
                        st_in = sodt_pkg::ST_BADNODE;
                        state_in = sodt_pkg::S_RESULT;
                     end else if (tsz == 4'd0) begin
                        st_in = sodt_pkg::ST_BADTYPE;
                        state_in = sodt_pkg::S_RESULT;
                     end else if (count_ff >= DepthC) begin
                        st_in = sodt_pkg::ST_FULL;
                        state_in = sodt_pkg::S_RESULT;
                     end
                  end
                  sodt_pkg::OP_SIZE, sodt_pkg::OP_READ, sodt_pkg::OP_WRMARK: begin
                     if (deftype) begin
                        st_in = sodt_pkg::ST_DEFTYPE;
                        state_in = sodt_pkg::S_RESULT;
                     end
                  end
                  sodt_pkg::OP_READCL, sodt_pkg::OP_WRITE: ;
                  sodt_pkg::OP_NEXTUP: begin
                     st_in = sodt_pkg::ST_NONEUPD;
                     state_in = sodt_pkg::S_SCAN_RD;
                  end
                  default: state_in = sodt_pkg::S_RESULT;
               endcase
            end
         end
         sodt_pkg::S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               state_in = sodt_pkg::S_SRCH_CMP;
            end else begin
               rd_addr = lo_ff[AW-1:0];
               state_in = sodt_pkg::S_PROBE;
            end
         end
         sodt_pkg::S_SRCH_CMP: begin
            if (rd_key < key_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = sodt_pkg::S_SEARCH;
         end
         sodt_pkg::S_PROBE: begin
            rd_addr = lo_ff[AW-1:0];
            state_in = sodt_pkg::S_PROBE_CMP;
         end
         sodt_pkg::S_PROBE_CMP: begin
            rd_addr = lo_ff[AW-1:0];
            state_in = sodt_pkg::S_RESULT;
            if (lo_ff < count_ff && rd_key == key_ff) begin
               if (op_ff == sodt_pkg::OP_INSERT) begin
                  st_in = sodt_pkg::ST_DUP;
               end else begin
                  osz_in = rd_size;
                  wr_addr = lo_ff[AW-1:0];
                  case (op_ff)
                     sodt_pkg::OP_READ: rv_in = rd_val;
                     sodt_pkg::OP_READCL: begin
                        rv_in = rd_val;
                        upd_in = rd_mark;
                        wr_en = 1'b1;
                        wr_data = {rd_ff[EW-1:1], 1'b0};
                     end
                     sodt_pkg::OP_WRMARK, sodt_pkg::OP_WRITE: begin
                        wr_en = 1'b1;
                        wr_data = {rd_key, rd_size,
                                   wval_ff & sodt_pkg::size_mask(rd_size),
                                   (op_ff == sodt_pkg::OP_WRMARK) | rd_mark};
                     end
                     default: ;
                  endcase
               end
            end else if (op_ff == sodt_pkg::OP_INSERT) begin
               ptr_in = count_ff;
               hold_in = {key_ff, isz_ff, 64'h0, 1'b0};
               state_in = sodt_pkg::S_SHIFT_RD;
            end else begin
               st_in = sodt_pkg::ST_MISSING;
            end
         end
         sodt_pkg::S_SHIFT_RD: begin
            rd_addr = AW'(ptr_ff - 1'b1);
            if (ptr_ff > lo_ff) begin
               state_in = sodt_pkg::S_SHIFT_WR;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = sodt_pkg::S_RESULT;
            end
         end
         sodt_pkg::S_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_data = rd_ff;
            ptr_in = ptr_ff - 1'b1;
            state_in = sodt_pkg::S_SHIFT_RD;
         end
         sodt_pkg::S_SCAN_RD: begin
            rd_addr = ptr_ff[AW-1:0];
            if (ptr_ff < count_ff) state_in = sodt_pkg::S_SCAN_CHK;
            else state_in = sodt_pkg::S_RESULT;
         end
         sodt_pkg::S_SCAN_CHK: begin
            rd_addr = ptr_ff[AW-1:0];
            if (rd_mark) begin
               st_in = sodt_pkg::ST_OK;
               osz_in = rd_size;
               rv_in = rd_val;
               upd_in = 1'b1;
               fkey_in = rd_key;
               wr_en = 1'b1;
               wr_data = {rd_ff[EW-1:1], 1'b0};
               state_in = sodt_pkg::S_RESULT;
            end else begin
               ptr_in = ptr_ff + 1'b1;
               state_in = sodt_pkg::S_SCAN_RD;
            end
         end
         sodt_pkg::S_RESULT: begin
            if (rsp_ready) state_in = sodt_pkg::S_IDLE;
         end
         default: state_in = sodt_pkg::S_IDLE;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC) else $error("entry count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> count_ff == $past(count_ff) + 1'b1
         && $past(op_ff) == sodt_pkg::OP_INSERT) else $error("bad count step");
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sodt_pkg::ST_OK |-> rsp_read_value == '0
         && rsp_object_size == '0 && !rsp_was_updated) else $error("dirty failure");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result held");

endmodule
`default_nettype wire

@@ test/tb_sorted_object_dictionary_table.sv @@
// ----------------------------------------------------------------------------
// Sorted object dictionary table testbench
// Drives insert, lookup, read, write and next-updated requests through the
// valid/ready channels while the configuration moves through several node and
// default-type ranges, and checks every response beat against a local
// key-sorted table kept in step with accepted requests. Near the end it fills
// the table to capacity.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sorted_object_dictionary_table;

   localparam int unsigned Depth = sodt_pkg::TableDepthDefault;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  node;
      logic [15:0] idx;
      logic [7:0]  sub;
      logic [15:0] dtype;
      logic [63:0] wval;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  size;
      logic [63:0] value;
      logic        updated;
      logic [7:0]  node;
      logic [15:0] idx;
      logic [7:0]  sub;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [7:0]  req_node_number = '0;
   logic [15:0] req_object_index = '0;
   logic [7:0]  req_object_subindex = '0;
   logic [15:0] req_data_type = '0;
   logic [63:0] req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_object_size;
   logic [63:0] rsp_read_value;
   logic        rsp_was_updated;
   logic [7:0]  rsp_found_node;
   logic [15:0] rsp_found_index;
   logic [7:0]  rsp_found_subindex;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sorted_object_dictionary_table u_dut (.*);

   always #1 clock = ~clock;

   // local copy of the table and registers
   logic [31:0] tbl_key [Depth];
   logic [3:0]  tbl_size [Depth];
   logic [63:0] tbl_value [Depth];
   logic        tbl_mark [Depth];
   int unsigned tbl_count = 0;
   logic [7:0]  node_min = 8'd1, node_max = 8'd127;
   logic [15:0] def_low = 16'd1, def_high = 16'd607;

   request_type request_q[$];
   outcome_type outcome_q[$];
   request_type cur;
   int unsigned gap_left = 0, burst_left = 0;
   int unsigned issued = 0, results_seen = 0, mismatches = 0, unexpected = 0;
   int unsigned hold_left = 0, ready_pct = 100;
   bit hold_done = 0;
   logic [7:0] status_seen = '0;
   int unsigned peak_count = 0;

   logic [7:0]  node_pool [4] = '{8'h01, 8'h05, 8'h7F, 8'hFA};
   logic [15:0] idx_pool [4] = '{16'h0000, 16'h0100, 16'h1000, 16'hFFFF};
   logic [15:0] type_codes [10] = '{16'h02, 16'h03, 16'h04, 16'h05, 16'h06,
                                    16'h07, 16'h08, 16'h11, 16'h15, 16'h1B};

   function automatic logic [3:0] bytes_of_type(logic [15:0] t);
      case (t)
         16'h02, 16'h05: return 4'd1;
         16'h03, 16'h06: return 4'd2;
         16'h04, 16'h07, 16'h08: return 4'd4;
         16'h11, 16'h15, 16'h1B: return 4'd8;
         default: return 4'd0;
      endcase
   endfunction

   function automatic outcome_type lookup_outcome(request_type r);
      outcome_type o;
      logic [31:0] k;
      int unsigned p;
      logic [3:0] sz;
      logic [63:0] mask;
      bit in_def;
      o = '0;
      k = {r.node, r.idx, r.sub};
      in_def = (r.idx >= def_low) && (r.idx <= def_high);
      p = 0;
      while (p < tbl_count && tbl_key[p] < k) p++;
      if (r.op == sodt_pkg::OP_INSERT) begin
         sz = bytes_of_type(r.dtype);
         if (r.node < node_min || r.node > node_max) o.status = sodt_pkg::ST_BADNODE;
         else if (sz == 0) o.status = sodt_pkg::ST_BADTYPE;
         else if (tbl_count >= Depth) o.status = sodt_pkg::ST_FULL;
         else if (p < tbl_count && tbl_key[p] == k) o.status = sodt_pkg::ST_DUP;
         else begin
            for (int i = tbl_count; i > p; i--) begin
               tbl_key[i] = tbl_key[i-1];
               tbl_size[i] = tbl_size[i-1];
               tbl_value[i] = tbl_value[i-1];
               tbl_mark[i] = tbl_mark[i-1];
            end
            tbl_key[p] = k;
            tbl_size[p] = sz;
            tbl_value[p] = '0;
            tbl_mark[p] = 1'b0;
            tbl_count++;
         end
      end else if (r.op == sodt_pkg::OP_NEXTUP) begin
         o.status = sodt_pkg::ST_NONEUPD;
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_mark[i]) begin
               o.status = sodt_pkg::ST_OK;
               o.size = tbl_size[i];
               o.value = tbl_value[i];
               o.updated = 1'b1;
               {o.node, o.idx, o.sub} = tbl_key[i];
               tbl_mark[i] = 1'b0;
               break;
            end
         end
      end else if (r.op != OP_UNUSED) begin
         if ((r.op == sodt_pkg::OP_SIZE || r.op == sodt_pkg::OP_READ
              || r.op == sodt_pkg::OP_WRMARK) && in_def)
            o.status = sodt_pkg::ST_DEFTYPE;
         else if (!(p < tbl_count && tbl_key[p] == k)) o.status = sodt_pkg::ST_MISSING;
         else begin
            o.size = tbl_size[p];
            if (r.op == sodt_pkg::OP_READ) o.value = tbl_value[p];
            else if (r.op == sodt_pkg::OP_READCL) begin
               o.value = tbl_value[p];
               o.updated = tbl_mark[p];
               tbl_mark[p] = 1'b0;
            end else if (r.op == sodt_pkg::OP_WRMARK || r.op == sodt_pkg::OP_WRITE) begin
               mask = (tbl_size[p] >= 8) ? '1 : ((64'd1 << (8 * tbl_size[p])) - 1);
               tbl_value[p] = r.wval & mask;
               if (r.op == sodt_pkg::OP_WRMARK) tbl_mark[p] = 1'b1;
            end
         end
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(lookup_outcome(cur));
            issued++;
            if (tbl_count > peak_count) peak_count = tbl_count;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               cur = request_q.pop_front();
               req_operation <= cur.op;
               req_node_number <= cur.node;
               req_object_index <= cur.idx;
               req_object_subindex <= cur.sub;
               req_data_type <= cur.dtype;
               req_write_value <= cur.wval;
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen == 150) begin
         hold_done = 1;
         hold_left = 600;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 60;
               default: ready_pct = 20;
            endcase
         end
         rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_object_size, rsp_read_value, rsp_was_updated,
                 rsp_found_node, rsp_found_index, rsp_found_subindex};
         results_seen++;
         if (outcome_q.size() == 0) begin
            unexpected++;
            $display("ERROR: response beat with nothing outstanding, status %0d", got.status);
         end else begin
            want = outcome_q.pop_front();
            status_seen[want.status] = 1'b1;
            if (got.status !== want.status || got.size !== want.size
                || got.value !== want.value || got.updated !== want.updated
                || got.node !== want.node || got.idx !== want.idx
                || got.sub !== want.sub) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("MISMATCH beat %0d: exp st=%0d sz=%0d val=%h upd=%b key=%h/%h/%h",
                           results_seen, want.status, want.size, want.value,
                           want.updated, want.node, want.idx, want.sub);
                  $display("   got st=%0d sz=%0d val=%h upd=%b key=%h/%h/%h",
                           got.status, got.size, got.value, got.updated,
                           got.node, got.idx, got.sub);
               end
            end
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      case (idx)
         sodt_pkg::CSR_NODE_MIN: node_min = data[7:0];
         sodt_pkg::CSR_NODE_MAX: node_max = data[7:0];
         sodt_pkg::CSR_DEF_LOW:  def_low = data;
         default:                def_high = data;
      endcase
   endtask

   task automatic set_ranges(logic [7:0] nmin, logic [7:0] nmax,
                             logic [15:0] dlo, logic [15:0] dhi);
      write_csr(sodt_pkg::CSR_NODE_MIN, {8'h00, nmin});
      write_csr(sodt_pkg::CSR_NODE_MAX, {8'h00, nmax});
      write_csr(sodt_pkg::CSR_DEF_LOW, dlo);
      write_csr(sodt_pkg::CSR_DEF_HIGH, dhi);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic request_type make_req(logic [2:0] op, logic [7:0] n, logic [15:0] i,
                                            logic [7:0] s, logic [15:0] t, logic [63:0] v);
      request_type r;
      r = '{op, n, i, s, t, v};
      return r;
   endfunction

   function automatic request_type random_req();
      request_type r;
      int unsigned w;
      w = $urandom_range(0, 99);
      if (w < 30) r.op = sodt_pkg::OP_INSERT;
      else if (w < 40) r.op = sodt_pkg::OP_SIZE;
      else if (w < 52) r.op = sodt_pkg::OP_READ;
      else if (w < 62) r.op = sodt_pkg::OP_READCL;
      else if (w < 74) r.op = sodt_pkg::OP_WRMARK;
      else if (w < 86) r.op = sodt_pkg::OP_WRITE;
      else if (w < 97) r.op = sodt_pkg::OP_NEXTUP;
      else r.op = OP_UNUSED;
      if ($urandom_range(0, 99) < 85) begin
         r.node = node_pool[$urandom_range(0, 3)];
         r.idx = idx_pool[$urandom_range(0, 3)];
         r.sub = 8'($urandom_range(0, 7));
      end else begin
         r.node = 8'($urandom);
         r.idx = 16'($urandom);
         r.sub = 8'($urandom);
      end
      r.dtype = ($urandom_range(0, 4) != 0) ? type_codes[$urandom_range(0, 9)]
                                            : 16'($urandom);
      r.wval = {$urandom, $urandom};
      return r;
   endfunction

   task automatic random_phase(int unsigned n);
      repeat (n) request_q.push_back(random_req());
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_ranges(8'd1, 8'd127, 16'd1, 16'd607);

      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd1, 16'h0000, 8'h00, 16'h02, '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd127, 16'hFFFF, 8'hFF, 16'h1B, '0));
      foreach (type_codes[i])
         request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd10, 16'h2000, 8'(i),
                                      type_codes[i], '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd0, 16'h2000, 8'h00, 16'h02, '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd128, 16'h2000, 8'h00, 16'h02, '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd10, 16'h2000, 8'h20, 16'hFFFF, '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'd10, 16'h2000, 8'h00, 16'h03, '0));
      request_q.push_back(make_req(sodt_pkg::OP_SIZE, 8'd10, 16'd607, 8'h00, '0, '0));
      request_q.push_back(make_req(sodt_pkg::OP_READ, 8'd10, 16'd1, 8'h00, '0, '0));
      request_q.push_back(make_req(sodt_pkg::OP_WRMARK, 8'd10, 16'd300, 8'h00, '0, '1));
      request_q.push_back(make_req(sodt_pkg::OP_WRMARK, 8'd10, 16'h2000, 8'h09, '0, '1));
      request_q.push_back(make_req(sodt_pkg::OP_WRITE, 8'd10, 16'h2000, 8'h00, '0, '1));
      request_q.push_back(make_req(sodt_pkg::OP_READ, 8'd10, 16'h2000, 8'h00, '0, '0));
      request_q.push_back(make_req(sodt_pkg::OP_READCL, 8'd10, 16'h2000, 8'h09, '0, '0));
      request_q.push_back(make_req(sodt_pkg::OP_WRMARK, 8'd127, 16'hFFFF, 8'hFF, '0,
                                   64'h0123_4567_89AB_CDEF));
      request_q.push_back(make_req(sodt_pkg::OP_NEXTUP, '0, '0, '0, '0, '0));
      request_q.push_back(make_req(sodt_pkg::OP_NEXTUP, '0, '0, '0, '0, '0));
      request_q.push_back(make_req(OP_UNUSED, 8'd10, 16'h2000, 8'h00, 16'h02, '1));
      request_q.push_back(make_req(sodt_pkg::OP_READ, 8'd99, 16'h3000, 8'h00, '0, '0));
      drain();
      random_phase(200);

      set_ranges(8'd0, 8'd255, 16'hFFFF, 16'h0000);
      random_phase(200);
      set_ranges(8'd200, 8'd10, 16'h0000, 16'hFFFF);
      random_phase(160);
      set_ranges(8'd0, 8'd255, 16'h1000, 16'h1000);
      random_phase(200);
      set_ranges(8'd5, 8'd250, 16'h0000, 16'h0000);
      random_phase(160);

      for (int i = 0; i < 300; i++)
         request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'h80, 16'(i), 8'h00,
                                      type_codes[$urandom_range(0, 9)], '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'h80, 16'h0000, 8'h00, 16'h02, '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'h80, 16'h0000, 8'h00, 16'h00, '0));
      request_q.push_back(make_req(sodt_pkg::OP_INSERT, 8'hFF, 16'h0000, 8'h00, 16'h02, '0));
      request_q.push_back(make_req(sodt_pkg::OP_WRMARK, 8'h80, 16'd255, 8'h00, '0,
                                   {$urandom, $urandom}));
      request_q.push_back(make_req(sodt_pkg::OP_NEXTUP, '0, '0, '0, '0, '0));
      drain();
      random_phase(60);
      repeat (600) @(posedge clock);

      $display("Run covered %0d requests, %0d response beats, peak table fill %0d of %0d.",
               issued, results_seen, peak_count, Depth);
      $display("Statuses seen (bit per code): %b", status_seen);
      if (mismatches == 0 && unexpected == 0 && outcome_q.size() == 0) begin
         $display("** sorted_object_dictionary_table: PASSED **");
      end else begin
         $display("%0d mismatches, %0d unexpected beats, %0d outstanding",
                  mismatches, unexpected, outcome_q.size());
         $display("** sorted_object_dictionary_table: FAILED **");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timeout with %0d responses outstanding", outcome_q.size());
      $display("** sorted_object_dictionary_table: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

@@ sorted_object_dictionary_table.f @@
src/sodt_pkg.sv
src/sorted_object_dictionary_table.sv
test/tb_sorted_object_dictionary_table.sv
